[sv/uvst_pkg.sv]
// shared types and codes of the unique value set table
package uvst_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_PRESENT   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_SH_CHK,
        S_SH_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] position;
        logic [3:0] entry_count;
    } out_word_t;

    typedef struct packed {
        logic    load;
        logic    idx_inc;
        logic    rd_en;
        logic    rd_next;
        logic    ins_wr;
        logic    sh_wr;
        logic    cnt_dec;
        logic    pos_set;
        logic    set_status;
        status_t status;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       idx_end;
        logic       sh_end;
        logic       match;
        logic       out_free;
    } dp_stat_t;

endpackage

[sv/uvst_ram.sv]
// generic simple dual-port ram with registered read
module uvst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/uvst_ctrl.sv]
// controller state machine of the unique value set table
module uvst_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  uvst_pkg::dp_stat_t  stat,
    output uvst_pkg::ctrl_cmd_t cmd
);
    import uvst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STAT_OK;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.cmd == CMD_INSERT && stat.full) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_FULL;
                    state_next     = S_FINISH;
                end else if (stat.idx_end) begin
                    cmd.set_status = 1'b1;
                    if (stat.cmd == CMD_INSERT) begin
                        cmd.ins_wr = 1'b1;
                        cmd.status = STAT_OK;
                    end else begin
                        cmd.status = STAT_NOT_FOUND;
                    end
                    state_next = S_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (stat.match) begin
                    cmd.set_status = 1'b1;
                    if (stat.cmd == CMD_INSERT) begin
                        cmd.status = STAT_PRESENT;
                        state_next = S_FINISH;
                    end else if (stat.cmd == CMD_REMOVE) begin
                        cmd.status  = STAT_OK;
                        cmd.pos_set = 1'b1;
                        cmd.cnt_dec = 1'b1;
                        state_next  = S_SH_CHK;
                    end else begin
                        cmd.status  = STAT_OK;
                        cmd.pos_set = 1'b1;
                        state_next  = S_FINISH;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_SH_CHK: begin
                if (stat.sh_end) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.sh_wr   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_SH_CHK;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/uvst_dp.sv]
// datapath: request registers, count, scan index, entry ram and result register
module uvst_dp #(
    parameter int CAPACITY = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  uvst_pkg::in_word_t   s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output uvst_pkg::out_word_t  m_word,
    input  uvst_pkg::ctrl_cmd_t  cmd,
    output uvst_pkg::dp_stat_t   stat
);
    import uvst_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [1:0]    cmd_reg,   cmd_next;
    logic [31:0]   value_reg, value_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg,   idx_next;
    logic [CW-1:0] pos_reg,   pos_next;
    status_t       status_reg, status_next;
    logic          m_valid_reg, m_valid_next;
    out_word_t     m_word_reg, m_word_next;

    logic [CW-1:0] idx_plus;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [31:0]   ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [31:0]   ram_rd_data;

    assign idx_plus = idx_reg + CW'(1);

    always_comb begin
        cmd_next     = cmd_reg;
        value_next   = value_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (cmd.load) begin
            cmd_next   = s_word.cmd;
            value_next = s_word.value;
            idx_next   = '0;
            pos_next   = '0;
        end
        if (cmd.idx_inc) begin
            idx_next = idx_plus;
        end
        if (cmd.pos_set) begin
            pos_next = idx_reg;
        end
        if (cmd.ins_wr) begin
            pos_next   = count_reg;
            count_next = count_reg + CW'(1);
        end
        if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.set_status) begin
            status_next = cmd.status;
        end
        if (cmd.out_load) begin
            m_valid_next            = 1'b1;
            m_word_next.status      = status_reg;
            m_word_next.position    = 3'(pos_reg);
            m_word_next.entry_count = 4'(count_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        m_word_reg <= m_word_next;
    end

    assign ram_wr_en   = cmd.ins_wr | cmd.sh_wr;
    assign ram_wr_addr = cmd.ins_wr ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign ram_wr_data = cmd.ins_wr ? value_reg : ram_rd_data;
    assign ram_rd_addr = cmd.rd_next ? idx_plus[AW-1:0] : idx_reg[AW-1:0];

    uvst_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign stat.cmd      = cmd_reg;
    assign stat.full     = (count_reg == CW'(CAPACITY));
    assign stat.idx_end  = (idx_reg == count_reg);
    assign stat.sh_end   = (idx_reg >= count_reg);
    assign stat.match    = (ram_rd_data == value_reg);
    assign stat.out_free = ~m_valid_reg | m_ready;

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

[sv/unique_value_set_table_unit.sv]
// top level of the unique value set table
//
//   channel   direction  handshake          word
//   s_        in         s_valid / s_ready  in_word_t  {cmd, value}
//   m_        out        m_valid / m_ready  out_word_t {status, position, entry_count}
//
// a scan step of the entry ram reads in S_CHECK and compares in S_CMP
// remove: the shift down of the later entries is done before the result is given
// reset clears the count and the result valid flag; entries need no clearing
// a result waiting on m_ready does not block the next word; the block only
// stalls when a second result is ready before the first is taken
module unique_value_set_table_unit #(
    parameter int CAPACITY = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  uvst_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output uvst_pkg::out_word_t m_word
);
    import uvst_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    uvst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (ctrl_cmd)
    );

    uvst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .cmd     (ctrl_cmd),
        .stat    (dp_stat)
    );

endmodule

[sv/uvst_checker.sv]
// port-level checks of the unique value set table and their binding
module uvst_checker #(
    parameter int CAPACITY = 8
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input uvst_pkg::in_word_t  s_word,
    input logic                m_valid,
    input logic                m_ready,
    input uvst_pkg::out_word_t m_word
);
    import uvst_pkg::*;

    // request word holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_word))
        else $error("request word dropped or changed while waiting");

    // result word holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word dropped or changed while stalled");

    // one word in flight
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while busy");

    // position only meaningful on success
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status != STAT_OK |-> m_word.position == 3'd0)
        else $error("position set on failed request");

    // full only reported at capacity
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status == STAT_FULL |-> m_word.entry_count == 4'(CAPACITY))
        else $error("table full reported below capacity");

endmodule

bind unique_value_set_table_unit uvst_checker #(
    .CAPACITY (CAPACITY)
) u_uvst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_word  (s_word),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

[bench/set_table_check.sv]
// channel monitor, table predictor and result comparison for the unique value set table
`timescale 1ns / 100ps

module set_table_check #(
    parameter int CAPACITY = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  uvst_pkg::in_word_t  s_word,
    input  logic                m_valid,
    input  logic                m_ready,
    input  uvst_pkg::out_word_t m_word,
    output int                  fail_count,
    output int                  pending
);
    import uvst_pkg::*;

    logic [31:0] stored_vals [CAPACITY];
    int          stored_cnt;
    out_word_t   awaited_replies [$];
    int          fails;

    task automatic apply_request(input in_word_t req, output out_word_t reply);
        int      hit;
        int      pos;
        status_t st;
        hit = -1;
        pos = 0;
        for (int i = 0; i < stored_cnt; i++) begin
            if (hit < 0 && stored_vals[i] == req.value) begin
                hit = i;
            end
        end
        case (req.cmd)
            CMD_INSERT: begin
                if (stored_cnt >= CAPACITY) begin
                    st = STAT_FULL;
                end else if (hit >= 0) begin
                    st = STAT_PRESENT;
                end else begin
                    stored_vals[stored_cnt] = req.value;
                    pos = stored_cnt;
                    stored_cnt++;
                    st = STAT_OK;
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    for (int i = hit; i < stored_cnt - 1; i++) begin
                        stored_vals[i] = stored_vals[i + 1];
                    end
                    stored_cnt--;
                    pos = hit;
                    st = STAT_OK;
                end else begin
                    st = STAT_NOT_FOUND;
                end
            end
            // lookup and the unused code
            default: begin
                if (hit >= 0) begin
                    pos = hit;
                    st = STAT_OK;
                end else begin
                    st = STAT_NOT_FOUND;
                end
            end
        endcase
        if (st != STAT_OK) begin
            pos = 0;
        end
        reply.status      = st;
        reply.position    = pos[2:0];
        reply.entry_count = stored_cnt[3:0];
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            awaited_replies.delete();
            stored_cnt = 0;
            fails      = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected word: status %0d position %0d count %0d",
                                 m_word.status, m_word.position, m_word.entry_count);
                    end
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_word.status !== want.status || m_word.position !== want.position
                        || m_word.entry_count !== want.entry_count) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: expected status %0d position %0d count %0d, %s",
                                     want.status, want.position, want.entry_count,
                                     $sformatf("got status %0d position %0d count %0d",
                                               m_word.status, m_word.position,
                                               m_word.entry_count));
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_request(s_word, want);
                awaited_replies.push_back(want);
            end
        end
        pending    <= awaited_replies.size();
        fail_count <= fails;
    end

endmodule

[bench/testbench.sv]
// stimulus, handshake pacing and verdict for the unique value set table
`timescale 1ns / 100ps

module testbench;
    import uvst_pkg::*;

    localparam int CAPACITY      = 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASE_WORDS   = 575;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    int          fail_count;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int          stall_cycles;
    logic [31:0] value_pool [12];

    unique_value_set_table_unit #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    set_table_check #(
        .CAPACITY(CAPACITY)
    ) u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #10 aclk = ~aclk;
        end
    end

    // receiver pacing, with an occasional long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [31:0] val);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_word  <= {op, val};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic refill_pool();
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'hffff_ffff;
        value_pool[3] = 32'h0000_0000;
        for (int i = 4; i < 12; i++) begin
            value_pool[i] = $urandom;
        end
    endtask

    task automatic random_phase(input int n_words);
        int          roll;
        logic [1:0]  op;
        logic [31:0] val;
        for (int i = 0; i < n_words; i++) begin
            if (i == n_words / 2) begin
                wait_drained();
            end
            roll = $urandom_range(99);
            if (roll < 40) begin
                op = CMD_INSERT;
            end else if (roll < 70) begin
                op = CMD_REMOVE;
            end else if (roll < 95) begin
                op = CMD_LOOKUP;
            end else begin
                op = CMD_UNUSED;
            end
            if ($urandom_range(99) < 75) begin
                val = value_pool[$urandom_range(11)];
            end else begin
                val = $urandom;
            end
            send_request(op, val);
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_word       = '0;
        m_ready      = 1'b0;
        hold_req     = 1'b0;
        stall_cycles = 0;
        tx_idle_pct  = 17;
        rx_idle_pct  = 58;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, extremes, duplicates, shift on removal, full table
        send_request(CMD_LOOKUP, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'h7fff_ffff);
        send_request(CMD_INSERT, 32'hffff_ffff);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'hffff_ffff);
        send_request(CMD_LOOKUP, 32'h7fff_ffff);
        send_request(CMD_UNUSED, 32'hffff_ffff);
        send_request(CMD_REMOVE, 32'h7fff_ffff);
        send_request(CMD_LOOKUP, 32'h0000_0000);
        for (int i = 1; i <= 5; i++) begin
            send_request(CMD_INSERT, i);
        end
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'h0000_0006);
        send_request(CMD_REMOVE, 32'h0000_0005);
        send_request(CMD_REMOVE, 32'h8000_0000);
        send_request(CMD_LOOKUP, 32'h5555_5555);
        send_request(CMD_REMOVE, 32'haaaa_aaaa);
        send_request(CMD_LOOKUP, 32'h0000_0004);
        send_request(CMD_UNUSED, 32'haaaa_aaaa);
        send_request(CMD_REMOVE, 32'hffff_ffff);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 58 : 0;
            rx_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 17 : 0;
            refill_pool();
            hold_req = 1'b1;
            random_phase(PHASE_WORDS);
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
